### rtl/core/p2rt_pkg.sv
package p2rt_pkg;

  localparam int COUNT_BITS_DEFAULT = 32;

  localparam int TPM_BITS  = 32;
  localparam int POLE_BITS = 8;
  localparam int RPM_BITS  = 16;

  localparam logic [TPM_BITS-1:0]  TPM_RESET  = 32'd960000000;
  localparam logic [POLE_BITS-1:0] POLE_RESET = 8'd7;
  localparam logic [RPM_BITS-1:0]  RPM_MAX    = {RPM_BITS{1'b1}};

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TPM  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POLE = 1'd1;

  // periods waiting between the counter and the divider
  localparam int FIFO_DEPTH = 2;

endpackage

### rtl/core/period_to_rpm_tachometer.sv
// Period-measuring tachometer.
// Input channel (in_valid/in_stall, motor_edge): one word per clock tick, with
// motor_edge high on a falling edge of the motor speed pulse. A saturating
// tick counter measures the period between edges; each edge word yields one
// output word speed_rpm = ticks_per_minute / (pole_count * period), floored
// and saturated at 65535 (also 65535 for a zero pole count).
// Ticks are counted per accepted input word. Each edge period goes into a
// two-entry queue; a divider behind it produces one quotient bit per cycle
// and pops the next period only once the current result has gone to the
// output register. in_stall rises only while the queue is full.
// Output channel (out_valid/out_stall, speed_rpm): a registered word that
// holds while out_stall is high; the divider finishes the next result behind
// it and waits, and once the queue fills the input stalls too.
// Configuration: cfg_write with cfg_index 0 sets ticks_per_minute, 1 sets
// pole_count (low 8 bits of cfg_data); write only while idle.
// Reset (rst, synchronous) clears the tick count and the queue, drops
// out_valid, and sets ticks_per_minute to 960000000 and pole_count to 7.
module period_to_rpm_tachometer import p2rt_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TPM_BITS-1:0]       cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      motor_edge,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RPM_BITS-1:0]       speed_rpm
);

  logic [TPM_BITS-1:0]   ticks_per_minute;
  logic [POLE_BITS-1:0]  pole_count;
  logic                  push;
  logic [COUNT_BITS-1:0] push_period;
  logic                  pop;
  logic [COUNT_BITS-1:0] pop_period;
  logic                  fifo_full;
  logic                  fifo_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_minute <= TPM_RESET;
      pole_count       <= POLE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TPM:  ticks_per_minute <= cfg_data;
        REG_POLE: pole_count       <= cfg_data[POLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  p2rt_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .motor_edge  (motor_edge),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_period (push_period)
  );

  p2rt_fifo #(
    .WIDTH (COUNT_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_period),
    .pop       (pop),
    .pop_data  (pop_period),
    .full      (fifo_full),
    .empty     (fifo_empty)
  );

  p2rt_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .ticks_per_minute (ticks_per_minute),
    .pole_count       (pole_count),
    .fifo_empty       (fifo_empty),
    .fifo_period      (pop_period),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .speed_rpm        (speed_rpm)
  );

endmodule

### rtl/core/p2rt_fifo.sv
module p2rt_fifo import p2rt_pkg::*; #(
  parameter int WIDTH = COUNT_BITS_DEFAULT,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full     = (count == CNT_FULL);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/p2rt_front.sv
module p2rt_front import p2rt_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  motor_edge,
  input  logic                  fifo_full,
  output logic                  push,
  output logic [COUNT_BITS-1:0] push_period
);

  logic [COUNT_BITS-1:0] elapsed;
  logic [COUNT_BITS-1:0] period;
  logic                  accept;

  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;

  // count this tick too; hold at all ones instead of wrapping
  assign period      = (&elapsed) ? elapsed : elapsed + 1'b1;
  assign push        = accept && motor_edge;
  assign push_period = period;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (accept) begin
      elapsed <= motor_edge ? '0 : period;
    end
  end

endmodule

### rtl/core/p2rt_back.sv
module p2rt_back import p2rt_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [TPM_BITS-1:0]   ticks_per_minute,
  input  logic [POLE_BITS-1:0]  pole_count,
  input  logic                  fifo_empty,
  input  logic [COUNT_BITS-1:0] fifo_period,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RPM_BITS-1:0]   speed_rpm
);

  localparam int DIV_BITS  = COUNT_BITS + POLE_BITS;
  localparam int CMP_BITS  = DIV_BITS + RPM_BITS;
  localparam int STEP_BITS = $clog2(RPM_BITS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(RPM_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]            state;
  logic [COUNT_BITS-1:0] period;
  logic [DIV_BITS-1:0]   divisor;
  logic [CMP_BITS-1:0]   dsh;
  logic [TPM_BITS-1:0]   rem;
  logic [RPM_BITS-1:0]   quot;
  logic [STEP_BITS-1:0]  step;
  logic                  out_free;
  logic                  fits;
  logic                  overflow;

  assign pop      = (state == S_IDLE) && !fifo_empty;
  assign out_free = !out_valid || !out_stall;
  assign fits     = (CMP_BITS'(rem) >= dsh);
  assign overflow = (divisor == '0) ||
                    (CMP_BITS'(ticks_per_minute) >= {divisor, {RPM_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        period <= fifo_period;
      end
      S_MUL: begin
        divisor <= DIV_BITS'(pole_count) * DIV_BITS'(period);
      end
      S_CHK: begin
        // the quotient fits in 16 bits, so one quotient bit per divisor shift
        rem  <= ticks_per_minute;
        dsh  <= {1'b0, divisor, {(RPM_BITS-1){1'b0}}};
        quot <= overflow ? RPM_MAX : '0;
        step <= '0;
      end
      S_DIV: begin
        if (fits) begin
          rem <= rem - dsh[TPM_BITS-1:0];
        end
        quot <= {quot[RPM_BITS-2:0], fits};
        dsh  <= dsh >> 1;
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (!fifo_empty) state <= S_MUL;
        S_MUL:  state <= S_CHK;
        S_CHK:  state <= overflow ? S_DONE : S_DIV;
        S_DIV:  if (step == STEP_LAST) state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      speed_rpm <= quot;
    end
  end

endmodule
